### design/cgb_pkg.sv
// ----------------------------------------------------------------------------
// Crossover gamete builder package
// Shared word types, function codes and the queue command format.
// ----------------------------------------------------------------------------
package cgb_pkg;

  // Function codes carried in the func field of an input word.
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_SITE  = 2'd2;

  // Input word as seen on the port.
  typedef struct packed {
    logic [1:0]  func;
    logic        start_chromosome;
    logic [31:0] position;
    logic [7:0]  allele_first;
    logic [7:0]  allele_second;
  } in_t;

  // Result word as seen on the port.
  typedef struct packed {
    logic [7:0]  allele_out;
    logic        source_chromosome;
    logic [15:0] site_index;
    logic        segment_start;
    logic        overflow;
  } out_t;

  // Classified operation held in the queue.
  typedef enum logic [1:0] {
    OP_START,
    OP_LOAD,
    OP_SITE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        start_chromosome;
    logic [31:0] position;
    logic [7:0]  allele_first;
    logic [7:0]  allele_second;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT
  } bk_state_e;

endpackage

### design/cgb_front.sv
// ----------------------------------------------------------------------------
// Crossover gamete builder front end
// Accepts input words, classifies the function code, discards undefined
// codes and queues commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module cgb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cgb_pkg::in_t  in_data_i,
  output logic          cmd_valid_o,
  output cgb_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  cgb_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    fill_q;
  logic          accept;
  logic          push;
  logic          pop;
  cgb_pkg::cmd_t cmd_new;
  logic          cmd_ok;

  // Classify the incoming word; undefined codes are accepted and dropped.
  always_comb begin
    cmd_new.start_chromosome = in_data_i.start_chromosome;
    cmd_new.position         = in_data_i.position;
    cmd_new.allele_first     = in_data_i.allele_first;
    cmd_new.allele_second    = in_data_i.allele_second;
    cmd_new.op               = cgb_pkg::OP_START;
    cmd_ok                   = 1'b1;
    unique case (in_data_i.func)
      cgb_pkg::FUNC_START: cmd_new.op = cgb_pkg::OP_START;
      cgb_pkg::FUNC_LOAD:  cmd_new.op = cgb_pkg::OP_LOAD;
      cgb_pkg::FUNC_SITE:  cmd_new.op = cgb_pkg::OP_SITE;
      default:             cmd_ok     = 1'b0;
    endcase
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign accept      = in_valid_i && in_ready_o;
  assign push        = accept && cmd_ok;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = entry_q[rd_ptr_q];

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

  // The fill level never exceeds the two entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q != 2'd3)
    else $error("queue fill level out of range");

  // A word is never written into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> fill_q != 2'd2)
    else $error("push into a full queue");

  // The back end only takes a command while one is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop_i |-> cmd_valid_o)
    else $error("pop from an empty queue");

endmodule

### design/cgb_back.sv
// ----------------------------------------------------------------------------
// Crossover gamete builder back end
// Holds the crossover store and gamete state, executes queued commands and
// drives the registered result word.
// ----------------------------------------------------------------------------
module cgb_back #(
  parameter int MAX_CROSSOVERS = 64,
  parameter int MAX_SITES      = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  cgb_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cgb_pkg::out_t out_data_o
);

  localparam int CNT_W  = $clog2(MAX_CROSSOVERS + 1);
  localparam int IDX_W  = (MAX_CROSSOVERS > 1) ? $clog2(MAX_CROSSOVERS) : 1;
  localparam int SITE_W = $clog2(MAX_SITES + 1);

  logic [31:0]         store_mem [MAX_CROSSOVERS];
  logic [31:0]         rdata_q;
  logic [CNT_W-1:0]    rd_addr;

  cgb_pkg::bk_state_e  state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, next_q, next_inc;
  logic [SITE_W-1:0]   site_q;
  logic                cur_src_q, prior_src_q, ovf_q;
  logic [31:0]         pos_q;
  logic [7:0]          a1_q, a2_q;
  logic                out_valid_q;
  cgb_pkg::out_t       out_q;

  logic out_free, hit, first, more, pending, site_full, store_full;
  logic src_scan, src_e;
  logic do_start, do_load, load_site, emit, adv;
  logic [7:0] sel_a1, sel_a2;

  assign out_free   = !out_valid_q || out_ready_i;
  assign hit        = rdata_q < pos_q;
  assign first      = (site_q == '0);
  assign next_inc   = next_q + CNT_W'(1);
  assign more       = next_inc < cnt_q;
  assign pending    = next_q < cnt_q;
  assign site_full  = site_q >= SITE_W'(MAX_SITES);
  assign store_full = cnt_q >= CNT_W'(MAX_CROSSOVERS);
  assign src_scan   = (hit && !first) ? ~cur_src_q : cur_src_q;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cgb_pkg::BK_IDLE: begin
        if (cmd_valid_i && cmd_i.op == cgb_pkg::OP_SITE && !site_full) begin
          if (pending) begin
            state_d = cgb_pkg::BK_SCAN;
          end else if (!out_free) begin
            state_d = cgb_pkg::BK_EMIT;
          end
        end
      end
      cgb_pkg::BK_SCAN: begin
        if (!(hit && more)) begin
          state_d = out_free ? cgb_pkg::BK_IDLE : cgb_pkg::BK_EMIT;
        end
      end
      cgb_pkg::BK_EMIT: begin
        if (out_free) begin
          state_d = cgb_pkg::BK_IDLE;
        end
      end
      default: state_d = cgb_pkg::BK_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    cmd_pop_o = 1'b0;
    do_start  = 1'b0;
    do_load   = 1'b0;
    load_site = 1'b0;
    emit      = 1'b0;
    adv       = 1'b0;
    src_e     = cur_src_q;
    sel_a1    = a1_q;
    sel_a2    = a2_q;
    unique case (state_q)
      cgb_pkg::BK_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        sel_a1    = cmd_i.allele_first;
        sel_a2    = cmd_i.allele_second;
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            cgb_pkg::OP_START: do_start = 1'b1;
            cgb_pkg::OP_LOAD:  do_load  = 1'b1;
            cgb_pkg::OP_SITE: begin
              if (!site_full) begin
                load_site = 1'b1;
                emit      = !pending && out_free;
              end
            end
            default: ;
          endcase
        end
      end
      cgb_pkg::BK_SCAN: begin
        adv   = hit;
        src_e = src_scan;
        emit  = !(hit && more) && out_free;
      end
      cgb_pkg::BK_EMIT: begin
        emit = out_free;
      end
      default: ;
    endcase
  end

  // Crossover store: one write port, one registered read port.
  assign rd_addr = (state_q == cgb_pkg::BK_SCAN) ? next_inc : next_q;

  always_ff @(posedge clk_i) begin
    if (do_load && !store_full) begin
      store_mem[cnt_q[IDX_W-1:0]] <= cmd_i.position;
    end
    rdata_q <= store_mem[rd_addr[IDX_W-1:0]];
  end

  // Sequencer state and gamete control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cgb_pkg::BK_IDLE;
      cnt_q       <= '0;
      next_q      <= '0;
      site_q      <= '0;
      cur_src_q   <= 1'b0;
      prior_src_q <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_start) begin
        cnt_q       <= '0;
        next_q      <= '0;
        site_q      <= '0;
        ovf_q       <= 1'b0;
        cur_src_q   <= cmd_i.start_chromosome;
        prior_src_q <= cmd_i.start_chromosome;
      end else begin
        if (do_load) begin
          if (store_full) begin
            ovf_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        if (adv) begin
          next_q    <= next_inc;
          cur_src_q <= src_scan;
        end
        if (emit) begin
          cur_src_q   <= src_e;
          prior_src_q <= src_e;
          site_q      <= site_q + SITE_W'(1);
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Site operands and the result word.
  always_ff @(posedge clk_i) begin
    if (load_site) begin
      pos_q <= cmd_i.position;
      a1_q  <= cmd_i.allele_first;
      a2_q  <= cmd_i.allele_second;
    end
    if (emit) begin
      out_q.allele_out        <= src_e ? sel_a2 : sel_a1;
      out_q.source_chromosome <= src_e;
      out_q.site_index        <= 16'(site_q);
      out_q.segment_start     <= first || (src_e != prior_src_q);
      out_q.overflow          <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The consume pointer never passes the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni) next_q <= cnt_q)
    else $error("consume pointer beyond fill count");

  // A scan cycle always has a stored crossover under examination.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cgb_pkg::BK_SCAN |-> next_q < cnt_q)
    else $error("scan without a pending crossover");

  // A result is never written over one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // The site count never runs past its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    site_q <= SITE_W'(MAX_SITES))
    else $error("site count beyond limit");

endmodule

### design/crossover_gamete_builder.sv
// ----------------------------------------------------------------------------
// Crossover gamete builder
// Builds one gamete site by site from two parental chromosomes.
// ----------------------------------------------------------------------------
// A start word and a load word are each executed as they leave the queue. A
// site word is emitted as it leaves the queue when every stored crossover
// has already been consumed. Otherwise it leaves the queue and starts the
// store read, and the scan then compares each crossover it consumes, plus
// the first entry not below the site when the scan stops before the end of
// the store. The crossover store gives one read per cycle, so entries are
// compared in turn. A result that finds the previous one still untaken
// holds the back end until the output register frees. A two-word queue
// separates the input side from the back end, so up to two new commands
// are queued while the back end is busy or a result waits. Crossover
// positions are expected in ascending order; later entries not below a site
// wait for later sites. Undefined function codes are accepted and dropped.
module crossover_gamete_builder #(
  parameter int MAX_CROSSOVERS = 64,
  parameter int MAX_SITES      = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cgb_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cgb_pkg::out_t out_data_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  cgb_pkg::cmd_t cmd;

  // Front end: classification and command queue.
  cgb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: crossover store, gamete state and result register.
  cgb_back #(
    .MAX_CROSSOVERS (MAX_CROSSOVERS),
    .MAX_SITES      (MAX_SITES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// Crossover gamete builder testbench
// Drives start, load and site words into the block and checks every result
// word against a cycle-free prediction of the gamete being built. A short
// directed sequence covers the edge cases. Randomised gametes then run under
// several idling patterns.
// ----------------------------------------------------------------------------
module tb;

  // Function code that the block must accept and drop.
  localparam logic [1:0] FUNC_UNDEF = 2'd3;

  localparam int STORE_DEPTH   = 64;
  localparam int SITE_LIMIT    = 65536;
  localparam int PHASE_WORDS   = 375;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 200;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  cgb_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  cgb_pkg::out_t out_data_o;

  // Idling controls, in percent of cycles.
  int    send_idle_pct  = 0;
  int    recv_stall_pct = 0;

  cgb_pkg::in_t  pending_words[$];
  cgb_pkg::out_t site_results_due[$];
  cgb_pkg::out_t oldest_site;
  int    words_queued = 0;
  int    mismatches   = 0;
  int    cycle_count  = 0;

  // Predicted gamete state.
  logic [31:0] xover_pos [STORE_DEPTH];
  int          xover_count    = 0;
  int          xover_next     = 0;
  int          sites_built    = 0;
  logic        cur_src        = 1'b0;
  logic        prev_src       = 1'b0;
  logic        store_overflow = 1'b0;

  crossover_gamete_builder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock generation.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Updates the predicted gamete for one accepted word and records the
  // result word that a site should produce.
  function void predict_gamete_word(cgb_pkg::in_t w);
    logic first;
    cgb_pkg::out_t r;
    case (w.func)
      cgb_pkg::FUNC_START: begin
        cur_src        = w.start_chromosome;
        prev_src       = w.start_chromosome;
        xover_count    = 0;
        xover_next     = 0;
        sites_built    = 0;
        store_overflow = 1'b0;
      end
      cgb_pkg::FUNC_LOAD: begin
        if (xover_count < STORE_DEPTH) begin
          xover_pos[xover_count] = w.position;
          xover_count++;
        end else begin
          store_overflow = 1'b1;
        end
      end
      cgb_pkg::FUNC_SITE: begin
        if (sites_built < SITE_LIMIT) begin
          first = (sites_built == 0);
          // Crossovers below the first site are skipped without a toggle.
          while (xover_next < xover_count && xover_pos[xover_next] < w.position) begin
            if (!first) begin
              cur_src = ~cur_src;
            end
            xover_next++;
          end
          r.allele_out        = cur_src ? w.allele_second : w.allele_first;
          r.source_chromosome = cur_src;
          r.site_index        = sites_built[15:0];
          r.segment_start     = first || (cur_src != prev_src);
          r.overflow          = store_overflow;
          site_results_due.push_back(r);
          prev_src = cur_src;
          sites_built++;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Appends one input word to the stimulus queue.
  function void queue_word(logic [1:0] f, logic chrom, logic [31:0] pos,
                           logic [7:0] first_allele, logic [7:0] second_allele);
    cgb_pkg::in_t w;
    w.func             = f;
    w.start_chromosome = chrom;
    w.position         = pos;
    w.allele_first     = first_allele;
    w.allele_second    = second_allele;
    pending_words.push_back(w);
    if (f != FUNC_UNDEF) begin
      words_queued++;
    end
  endfunction

  // One random gamete: a start word, crossover loads and site words, with
  // occasional interleaving, unsorted loads, store overflow and noise words.
  task automatic queue_gamete();
    int          nx;
    int          ns;
    int          loaded;
    int          sited;
    bit          unsorted;
    bit          interleave;
    logic [31:0] x_step;
    logic [31:0] s_step;
    logic [31:0] x_pos;
    logic [31:0] s_pos;
    nx         = ($urandom_range(9) == 0) ? $urandom_range(70, 58) : $urandom_range(6);
    ns         = $urandom_range(20, 1);
    unsorted   = ($urandom_range(9) == 0);
    interleave = ($urandom_range(3) == 0);
    x_step     = 32'hFFFF_FFFF / (nx + 1);
    s_step     = 32'hFFFF_FFFF / ns;
    x_pos      = 32'd0;
    s_pos      = 32'd0;
    loaded     = 0;
    sited      = 0;
    queue_word(cgb_pkg::FUNC_START, 1'($urandom), $urandom, 8'($urandom), 8'($urandom));
    while (loaded < nx || sited < ns) begin
      if (loaded < nx && (sited >= ns || !interleave || $urandom_range(1) == 0)) begin
        x_pos = unsorted ? $urandom : x_pos + $urandom_range(x_step);
        queue_word(cgb_pkg::FUNC_LOAD, 1'($urandom), x_pos, 8'($urandom), 8'($urandom));
        loaded++;
      end else begin
        s_pos = s_pos + $urandom_range(s_step);
        queue_word(cgb_pkg::FUNC_SITE, 1'($urandom), s_pos, 8'($urandom), 8'($urandom));
        sited++;
      end
      // Noise: any function code, fields fully random.
      if ($urandom_range(24) == 0) begin
        queue_word(2'($urandom_range(3)), 1'($urandom), $urandom,
                   8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Waits until every queued word is accepted and every result has arrived.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || site_results_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Sets the idling pattern and runs one batch of random gametes under it.
  task automatic run_phase(int send_pct, int recv_pct);
    int first_word;
    @(negedge clk_i);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
    first_word = words_queued;
    while (words_queued - first_word < PHASE_WORDS) begin
      queue_gamete();
    end
    wait_drained();
  endtask

  // Driver: presents queued words and updates the prediction on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_gamete_word(in_data_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest expected site.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (site_results_due.size() == 0) begin
          $error("result word with no site outstanding: %p", out_data_o);
          mismatches++;
        end else begin
          oldest_site = site_results_due.pop_front();
          if (out_data_o.allele_out !== oldest_site.allele_out) begin
            $error("allele_out: expected %0h, got %0h",
                   oldest_site.allele_out, out_data_o.allele_out);
            mismatches++;
          end
          if (out_data_o.source_chromosome !== oldest_site.source_chromosome) begin
            $error("source_chromosome: expected %0d, got %0d",
                   oldest_site.source_chromosome, out_data_o.source_chromosome);
            mismatches++;
          end
          if (out_data_o.site_index !== oldest_site.site_index) begin
            $error("site_index: expected %0d, got %0d",
                   oldest_site.site_index, out_data_o.site_index);
            mismatches++;
          end
          if (out_data_o.segment_start !== oldest_site.segment_start) begin
            $error("segment_start: expected %0d, got %0d",
                   oldest_site.segment_start, out_data_o.segment_start);
            mismatches++;
          end
          if (out_data_o.overflow !== oldest_site.overflow) begin
            $error("overflow: expected %0d, got %0d",
                   oldest_site.overflow, out_data_o.overflow);
            mismatches++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Crossover below the first site, a site equal to a crossover, toggles,
    // extreme positions and alleles, and an undefined function code.
    queue_word(cgb_pkg::FUNC_START, 1'b0, 32'h0, 8'h00, 8'h00);
    queue_word(cgb_pkg::FUNC_LOAD,  1'b0, 32'h0000_0010, 8'h00, 8'h00);
    queue_word(cgb_pkg::FUNC_LOAD,  1'b0, 32'h0100_0000, 8'h00, 8'h00);
    queue_word(cgb_pkg::FUNC_LOAD,  1'b0, 32'h0200_0000, 8'h00, 8'h00);
    queue_word(cgb_pkg::FUNC_SITE,  1'b0, 32'h0080_0000, 8'h00, 8'hFF);
    queue_word(cgb_pkg::FUNC_SITE,  1'b0, 32'h0100_0000, 8'h12, 8'h34);
    queue_word(cgb_pkg::FUNC_SITE,  1'b0, 32'h0100_0001, 8'h56, 8'h78);
    queue_word(FUNC_UNDEF,          1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    queue_word(cgb_pkg::FUNC_SITE,  1'b1, 32'hFFFF_FFFF, 8'hFF, 8'h00);
    queue_word(cgb_pkg::FUNC_SITE,  1'b0, 32'hFFFF_FFFF, 8'hAA, 8'h55);
    // Second chromosome start with unsorted loads.
    queue_word(cgb_pkg::FUNC_START, 1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    queue_word(cgb_pkg::FUNC_LOAD,  1'b1, 32'h8000_0000, 8'h00, 8'h00);
    queue_word(cgb_pkg::FUNC_LOAD,  1'b1, 32'h1000_0000, 8'h00, 8'h00);
    queue_word(cgb_pkg::FUNC_SITE,  1'b1, 32'h0000_0000, 8'hFF, 8'hFF);
    queue_word(cgb_pkg::FUNC_SITE,  1'b1, 32'h9000_0000, 8'h01, 8'h80);
    queue_word(cgb_pkg::FUNC_LOAD,  1'b1, 32'hFFFF_FFFF, 8'h00, 8'h00);
    queue_word(cgb_pkg::FUNC_SITE,  1'b1, 32'hFFFF_FFFF, 8'h7F, 8'hFE);
    // Gamete with no crossovers at all.
    queue_word(cgb_pkg::FUNC_START, 1'b0, 32'h0, 8'h00, 8'h00);
    queue_word(cgb_pkg::FUNC_SITE,  1'b0, 32'hA5A5_A5A5, 8'h5A, 8'hA5);
    queue_word(cgb_pkg::FUNC_SITE,  1'b1, 32'h5A5A_5A5A, 8'hC3, 8'h3C);
    wait_drained();

    run_phase(0, 0);
    run_phase(86, 0);
    run_phase(0, 86);
    run_phase(22, 22);

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
